[rtl/core/sosfg_pkg.sv]
// ----------------------------------------------------------------------------
// sosfg_pkg
// Shared types, constants and sine/cosine microcode for the fading gain block.
// ----------------------------------------------------------------------------
package sosfg_pkg;

	localparam int MAX_PATHS_DEF = 16;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 24;
	localparam int POWER_W    = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int NP_W       = 5;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_PATHS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVES     = 2'd1;

	localparam logic [NP_W-1:0] NUM_PATHS_RST = 5'd8;
	localparam logic [31:0]     WAVES_RST     = 32'd134310003;

	localparam logic [POWER_W-1:0] POWER_MAX = 21'd1048576;

	// divider operand widths
	localparam int DIV_DW = 52;
	localparam int DIV_SW = 29;

	// floor(p / 1000) as ((p >> 3) * ceil(2^56 / 125)) >> 56, halves of the multiplier
	localparam logic [31:0] DOP_RECIP_LO = 32'd3126736192;
	localparam logic [31:0] DOP_RECIP_HI = 32'd134217;

	// sine/cosine constants, Q2.30
	localparam logic [31:0] Q30_ONE = 32'd1073741824;
	localparam logic [31:0] K_PI4   = 32'd843314857;
	localparam logic [31:0] M_DIV6  = 32'd2863311531;
	localparam logic [31:0] M_DIV12 = 32'd2863311531;
	localparam logic [31:0] M_DIV20 = 32'd3435973837;
	localparam logic [31:0] M_DIV30 = 32'd2290649225;
	localparam logic [31:0] M_DIV42 = 32'd3272356036;
	localparam logic [31:0] M_DIV56 = 32'd2454267027;

	localparam logic [1:0] A_W  = 2'd0;
	localparam logic [1:0] A_DV = 2'd1;
	localparam logic [1:0] A_X  = 2'd2;
	localparam logic [1:0] A_X2 = 2'd3;

	localparam logic [3:0] SC_LAST = 4'd14;

	typedef struct packed {
		logic [1:0]  a_sel;
		logic        b_dv;
		logic [31:0] b_const;
		logic [5:0]  sh;
		logic        sub;
	} uop_t;

	// one multiply per step; sh/sub post-process the product for the next step
	function automatic uop_t sc_uop(input logic [3:0] step);
		uop_t u;
		u = '{a_sel: A_W, b_dv: 1'b0, b_const: 32'd0, sh: 6'd0, sub: 1'b0};
		unique case (step)
			4'd0:  u = '{a_sel: A_W,  b_dv: 1'b0, b_const: K_PI4,   sh: 6'd21, sub: 1'b0};
			4'd1:  u = '{a_sel: A_DV, b_dv: 1'b1, b_const: 32'd0,   sh: 6'd30, sub: 1'b0};
			4'd2:  u = '{a_sel: A_DV, b_dv: 1'b0, b_const: M_DIV42, sh: 6'd37, sub: 1'b1};
			4'd3:  u = '{a_sel: A_X2, b_dv: 1'b1, b_const: 32'd0,   sh: 6'd30, sub: 1'b0};
			4'd4:  u = '{a_sel: A_DV, b_dv: 1'b0, b_const: M_DIV20, sh: 6'd36, sub: 1'b1};
			4'd5:  u = '{a_sel: A_X2, b_dv: 1'b1, b_const: 32'd0,   sh: 6'd30, sub: 1'b0};
			4'd6:  u = '{a_sel: A_DV, b_dv: 1'b0, b_const: M_DIV6,  sh: 6'd34, sub: 1'b1};
			4'd7:  u = '{a_sel: A_X,  b_dv: 1'b1, b_const: 32'd0,   sh: 6'd30, sub: 1'b0};
			4'd8:  u = '{a_sel: A_X2, b_dv: 1'b0, b_const: M_DIV56, sh: 6'd37, sub: 1'b1};
			4'd9:  u = '{a_sel: A_X2, b_dv: 1'b1, b_const: 32'd0,   sh: 6'd30, sub: 1'b0};
			4'd10: u = '{a_sel: A_DV, b_dv: 1'b0, b_const: M_DIV30, sh: 6'd36, sub: 1'b1};
			4'd11: u = '{a_sel: A_X2, b_dv: 1'b1, b_const: 32'd0,   sh: 6'd30, sub: 1'b0};
			4'd12: u = '{a_sel: A_DV, b_dv: 1'b0, b_const: M_DIV12, sh: 6'd35, sub: 1'b1};
			4'd13: u = '{a_sel: A_X2, b_dv: 1'b1, b_const: 32'd0,   sh: 6'd31, sub: 1'b1};
			default: u = '{a_sel: A_W, b_dv: 1'b0, b_const: 32'd0, sh: 6'd0, sub: 1'b0};
		endcase
		return u;
	endfunction

endpackage

[rtl/core/sosfg_ram.sv]
// ----------------------------------------------------------------------------
// sosfg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sosfg_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/sosfg_mul.sv]
// ----------------------------------------------------------------------------
// sosfg_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module sosfg_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;

endmodule

[rtl/core/sosfg_div.sv]
// ----------------------------------------------------------------------------
// sosfg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sosfg_div
	import sosfg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_DW-1:0] dividend,
	input  logic [DIV_SW-1:0] divisor,
	output logic [DIV_DW-1:0] quotient,
	output logic              done
);

	localparam int CNT_W = $clog2(DIV_DW + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [DIV_DW-1:0] dvd_q;
	logic [DIV_SW-1:0] dsr_q;
	logic [DIV_SW-1:0] rem_q;
	logic [DIV_SW:0]   r2;
	logic              ge;

	assign r2 = {rem_q, dvd_q[DIV_DW-1]};
	assign ge = r2 >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? DIV_SW'(r2 - {1'b0, dsr_q}) : DIV_SW'(r2);
			dvd_q <= {dvd_q[DIV_DW-2:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign done     = done_q;

endmodule

[rtl/core/sum_of_sinusoids_fading_gain.sv]
// ----------------------------------------------------------------------------
// sum_of_sinusoids_fading_gain
// Multipath fading power gain by a fixed-point sum of sinusoids.
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one path entry. An evaluate item (tuser 1)
// with n paths goes straight to its result when the path count is zero;
// else the Doppler shift is formed as a reciprocal multiplication in four
// passes through the shared 32x32 multiplier, then the Doppler-time
// product, then each path needs one table read, a phase step and fifteen
// multiplier passes for its sine and cosine polynomials, and the power takes
// the squaring of both sums and the division by n in the restoring divider.
// The input is not ready while an item is at work. A finished result moves
// into the output register once that is free; until then it waits in the
// done state and the input stays not ready.
module sum_of_sinusoids_fading_gain #(
	parameter int MAX_PATHS = sosfg_pkg::MAX_PATHS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// path_index, cos_angle, delay_phase, relative_speed, sample_time
	input  logic [sosfg_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// channel_power
	output logic [sosfg_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sosfg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sosfg_pkg::CFG_DATA_W-1:0] cfg_data
);

	import sosfg_pkg::*;

	localparam int AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_DOP0 = 5'd1;
	localparam logic [4:0] ST_DOP1 = 5'd2;
	localparam logic [4:0] ST_DOP2 = 5'd3;
	localparam logic [4:0] ST_DOP3 = 5'd4;
	localparam logic [4:0] ST_DOP4 = 5'd5;
	localparam logic [4:0] ST_DOP5 = 5'd6;
	localparam logic [4:0] ST_Q0   = 5'd7;
	localparam logic [4:0] ST_Q1   = 5'd8;
	localparam logic [4:0] ST_Q2   = 5'd9;
	localparam logic [4:0] ST_Q3   = 5'd10;
	localparam logic [4:0] ST_RD   = 5'd11;
	localparam logic [4:0] ST_PH0  = 5'd12;
	localparam logic [4:0] ST_PH1  = 5'd13;
	localparam logic [4:0] ST_PH2  = 5'd14;
	localparam logic [4:0] ST_SC   = 5'd15;
	localparam logic [4:0] ST_SQ0  = 5'd16;
	localparam logic [4:0] ST_SQ1  = 5'd17;
	localparam logic [4:0] ST_SQ2  = 5'd18;
	localparam logic [4:0] ST_SQW  = 5'd19;
	localparam logic [4:0] ST_DONE = 5'd20;

	logic [4:0]         state_q;
	logic [NP_W-1:0]    num_paths_q;
	logic [31:0]        waves_q;
	logic [NP_W-1:0]    n_q;
	logic [NP_W-1:0]    n_eff;
	logic [NP_W-1:0]    path_q;
	logic [19:0]        speed_q;
	logic [39:0]        time_q;
	logic [48:0]        dy_q;
	logic [42:0]        dop_q;
	logic [62:0]        q_q;
	logic [63:0]        acc_q;
	logic [2:0]         oct_q;
	logic [21:0]        w_q;
	logic [3:0]         sc_q;
	logic [5:0]         post_sh_q;
	logic               post_sub_q;
	logic [31:0]        x_q;
	logic [31:0]        x2_q;
	logic [31:0]        sm_q;
	logic signed [26:0] re_q;
	logic signed [26:0] im_q;
	logic               out_valid_q;
	logic [POWER_W-1:0] res_q;
	logic [POWER_W-1:0] power_q;

	logic [3:0]  in_path;
	logic [15:0] in_cos;
	logic [23:0] in_delay;
	logic [19:0] in_speed;
	logic [39:0] in_time;

	logic              load_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	logic [15:0]       ang_rd;
	logic [23:0]       dly_rd;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       mul_p;

	logic              div_start;
	logic [DIV_DW-1:0] div_dvd;
	logic [DIV_SW-1:0] div_dsr;
	logic [DIV_DW-1:0] div_quo;
	logic              div_done;

	uop_t        uop;
	logic [63:0] dv64;
	logic [31:0] dv;

	logic [62:0]        ph_sum;
	logic [23:0]        ph_frac;
	logic [23:0]        phase;
	logic [32:0]        sm_rnd;
	logic [32:0]        cm_rnd;
	logic signed [26:0] sm_v;
	logic signed [26:0] cm_v;
	logic signed [26:0] s0;
	logic signed [26:0] c0;
	logic signed [26:0] sv;
	logic signed [26:0] cv;
	logic [31:0]        re_abs;
	logic [31:0]        im_abs;
	logic               out_free;

	assign in_path  = s_tdata[3:0];
	assign in_cos   = s_tdata[19:4];
	assign in_delay = s_tdata[43:20];
	assign in_speed = s_tdata[63:44];
	assign in_time  = s_tdata[103:64];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(OUT_DATA_W - POWER_W){1'b0}}, power_q};
	assign out_free  = !out_valid_q || m_tready;

	assign n_eff = (32'(num_paths_q) > MAX_PATHS) ? NP_W'(MAX_PATHS) : num_paths_q;

	assign load_we   = s_tvalid && s_tready && (s_tuser == OP_LOAD)
		&& (32'(in_path) < MAX_PATHS);
	assign ram_waddr = AW'(in_path);
	assign ram_raddr = AW'(path_q);

	sosfg_ram #(.WIDTH(16), .DEPTH(MAX_PATHS), .ADDR_W(AW)) u_angle_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (ram_waddr),
		.wdata (in_cos),
		.raddr (ram_raddr),
		.rdata (ang_rd)
	);

	sosfg_ram #(.WIDTH(24), .DEPTH(MAX_PATHS), .ADDR_W(AW)) u_delay_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (ram_waddr),
		.wdata (in_delay),
		.raddr (ram_raddr),
		.rdata (dly_rd)
	);

	sosfg_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	sosfg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.done     (div_done)
	);

	// post-processed product of the previous sine/cosine step
	assign uop  = sc_uop(sc_q);
	assign dv64 = mul_p >> post_sh_q;
	assign dv   = post_sub_q ? (Q30_ONE - dv64[31:0]) : dv64[31:0];

	assign re_abs = re_q[26] ? 32'(-re_q) : 32'(re_q);
	assign im_abs = im_q[26] ? 32'(-im_q) : 32'(im_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DOP0: begin
				mul_a = 32'(speed_q);
				mul_b = waves_q;
			end
			ST_DOP1: begin
				mul_a = mul_p[34:3];
				mul_b = DOP_RECIP_LO;
			end
			ST_DOP2: begin
				mul_a = dy_q[31:0];
				mul_b = DOP_RECIP_HI;
			end
			ST_DOP3: begin
				mul_a = 32'(dy_q[48:32]);
				mul_b = DOP_RECIP_LO;
			end
			ST_DOP4: begin
				mul_a = 32'(dy_q[48:32]);
				mul_b = DOP_RECIP_HI;
			end
			ST_Q0: begin
				mul_a = dop_q[31:0];
				mul_b = time_q[31:0];
			end
			ST_Q1: begin
				mul_a = dop_q[31:0];
				mul_b = 32'(time_q[39:32]);
			end
			ST_Q2: begin
				mul_a = 32'(dop_q[42:32]);
				mul_b = time_q[31:0];
			end
			ST_PH0: begin
				mul_a = 32'(ang_rd);
				mul_b = q_q[31:0];
			end
			ST_PH1: begin
				mul_a = 32'(ang_rd);
				mul_b = 32'(q_q[62:32]);
			end
			ST_SC: begin
				unique case (uop.a_sel)
					A_W:     mul_a = 32'(w_q);
					A_DV:    mul_a = dv;
					A_X:     mul_a = x_q;
					A_X2:    mul_a = x2_q;
					default: mul_a = '0;
				endcase
				mul_b = uop.b_dv ? dv : uop.b_const;
			end
			ST_SQ0: begin
				mul_a = re_abs;
				mul_b = re_abs;
			end
			ST_SQ1: begin
				mul_a = im_abs;
				mul_b = im_abs;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_SQ2);
	assign div_dvd   = DIV_DW'(acc_q + mul_p) + (DIV_DW'(n_q) << 23);
	assign div_dsr   = DIV_SW'(n_q) << 24;

	// path phase and octant
	assign ph_sum  = 63'(acc_q) + {mul_p[30:0], 32'd0}
		- (ang_rd[15] ? {q_q[46:0], 16'd0} : 63'd0);
	assign ph_frac = ph_sum[62:39];
	assign phase   = ph_frac - dly_rd;

	// rounding to Q1.20 and quadrant signs
	assign sm_rnd = 33'(sm_q) + 33'd512;
	assign cm_rnd = 33'(dv) + 33'd512;
	assign sm_v   = signed'(27'(sm_rnd >> 10));
	assign cm_v   = signed'(27'(cm_rnd >> 10));
	assign s0     = oct_q[0] ? cm_v : sm_v;
	assign c0     = oct_q[0] ? sm_v : cm_v;

	always_comb begin
		unique case (oct_q[2:1])
			2'd0: begin
				sv = s0;
				cv = c0;
			end
			2'd1: begin
				sv = c0;
				cv = -s0;
			end
			2'd2: begin
				sv = -s0;
				cv = -c0;
			end
			default: begin
				sv = -c0;
				cv = s0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_paths_q <= NUM_PATHS_RST;
			waves_q     <= WAVES_RST;
			out_valid_q <= 1'b0;
			path_q      <= '0;
			sc_q        <= '0;
			n_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_NUM_PATHS) begin
					num_paths_q <= cfg_data[NP_W-1:0];
				end else if (cfg_index == REG_WAVES) begin
					waves_q <= cfg_data;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tuser == OP_EVAL) begin
						n_q     <= n_eff;
						state_q <= (n_eff == '0) ? ST_DONE : ST_DOP0;
					end
				end
				ST_DOP0: state_q <= ST_DOP1;
				ST_DOP1: state_q <= ST_DOP2;
				ST_DOP2: state_q <= ST_DOP3;
				ST_DOP3: state_q <= ST_DOP4;
				ST_DOP4: state_q <= ST_DOP5;
				ST_DOP5: state_q <= ST_Q0;
				ST_Q0: state_q <= ST_Q1;
				ST_Q1: state_q <= ST_Q2;
				ST_Q2: state_q <= ST_Q3;
				ST_Q3: begin
					path_q  <= '0;
					state_q <= ST_RD;
				end
				ST_RD:  state_q <= ST_PH0;
				ST_PH0: state_q <= ST_PH1;
				ST_PH1: state_q <= ST_PH2;
				ST_PH2: begin
					sc_q    <= '0;
					state_q <= ST_SC;
				end
				ST_SC: begin
					sc_q <= sc_q + 1'b1;
					if (sc_q == SC_LAST) begin
						path_q  <= path_q + 1'b1;
						state_q <= (path_q + 1'b1 == n_q) ? ST_SQ0 : ST_RD;
					end
				end
				ST_SQ0: state_q <= ST_SQ1;
				ST_SQ1: state_q <= ST_SQ2;
				ST_SQ2: state_q <= ST_SQW;
				ST_SQW: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				speed_q <= in_speed;
				time_q  <= in_time;
				res_q   <= '0;
			end
			ST_DOP1: dy_q <= mul_p[51:3];
			ST_DOP2: acc_q <= 64'(mul_p[63:32]);
			ST_DOP3: acc_q <= acc_q + mul_p;
			ST_DOP4: acc_q <= acc_q + mul_p;
			ST_DOP5: dop_q <= 43'(acc_q[63:24]) + {mul_p[34:0], 8'd0};
			ST_Q1: acc_q <= mul_p;
			ST_Q2: acc_q <= acc_q + {mul_p[31:0], 32'd0};
			ST_Q3: begin
				q_q  <= 63'(acc_q + {mul_p[31:0], 32'd0});
				re_q <= '0;
				im_q <= '0;
			end
			ST_PH1: acc_q <= mul_p;
			ST_PH2: begin
				oct_q <= phase[23:21];
				w_q   <= phase[21] ? (22'h200000 - 22'(phase[20:0])) : 22'(phase[20:0]);
			end
			ST_SC: begin
				post_sh_q  <= uop.sh;
				post_sub_q <= uop.sub;
				if (sc_q == 4'd1) begin
					x_q <= dv;
				end
				if (sc_q == 4'd2) begin
					x2_q <= dv;
				end
				if (sc_q == 4'd8) begin
					sm_q <= dv;
				end
				if (sc_q == SC_LAST) begin
					re_q <= re_q + cv;
					im_q <= im_q - sv;
				end
			end
			ST_SQ1: acc_q <= mul_p;
			ST_SQW: begin
				if (div_done) begin
					res_q <= (div_quo > DIV_DW'(POWER_MAX)) ? POWER_MAX
						: div_quo[POWER_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					power_q <= res_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_SQW))
		else $error("divider finished outside a wait state");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[POWER_W-1:0] <= POWER_MAX))
		else $error("channel power above range");

	a_path_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC) |-> (path_q < n_q))
		else $error("path counter beyond path count");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == OP_EVAL) |=> (state_q != ST_IDLE))
		else $error("evaluate item accepted without starting");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result dropped while output busy");
`endif

endmodule
